FILE: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the voxel hash insert block.
// Assertions are removed when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

FILE: rtl/vhi_pkg.sv
// Package of the voxel hash insert block: sizes, primes, status codes, types.
// No dependencies.
`timescale 1ns / 1ps
package vhi_pkg;
  localparam int unsigned Buckets   = 4096;
  localparam int unsigned PoolNodes = 4096;
  localparam int unsigned BktW  = $clog2(Buckets);
  localparam int unsigned NodeW = $clog2(PoolNodes);
  localparam int unsigned CntW  = NodeW + 1;
  localparam logic [31:0] PrimeX = 32'd73856093;
  localparam logic [31:0] PrimeY = 32'd19349669;
  localparam logic [31:0] PrimeZ = 32'd83492791;

  typedef enum logic [1:0] {
    ST_PRESENT = 2'd0,
    ST_HEAD    = 2'd1,
    ST_CHAIN   = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] bucket;
    logic [31:0] cell_x;
    logic [31:0] cell_y;
    logic [31:0] cell_z;
    logic [12:0] voxel_total;
    logic [12:0] chained_total;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic neg;
  } div_ctrl_t;
endpackage

FILE: rtl/vhi_if.sv
// Valid/ready channel interfaces for the voxel hash insert block.
// Depends on vhi_pkg.
`timescale 1ns / 1ps
interface vhi_in_if import vhi_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vhi_out_if import vhi_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vhi_cfg_if ();
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/vhi_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module vhi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: rtl/vhi_div.sv
// Restoring divider, one quotient bit per cycle, giving a signed floor quotient.
// Depends on vhi_pkg.
`timescale 1ns / 1ps
module vhi_div import vhi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  div_ctrl_t   ctrl_i,
  input  logic [31:0] mag_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o
);
  logic [31:0] q_q, q_d, d_q, d_d;
  logic [32:0] r_q, r_d;
  logic [33:0] trial;
  logic [5:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d, busy_q, busy_d;
  logic [31:0] qadj;

  assign trial = {1'b0, r_q[31:0], q_q[31]} - {2'b00, d_q};

  always_comb begin
    q_d = q_q; r_d = r_q; d_d = d_q; cnt_d = cnt_q; neg_d = neg_q; busy_d = busy_q;
    if (ctrl_i.start) begin
      q_d = mag_i; r_d = '0; cnt_d = 6'd32; neg_d = ctrl_i.neg; busy_d = 1'b1;
      d_d = (divisor_i == '0) ? 32'd1 : divisor_i;
    end else if (busy_q) begin
      if (!trial[33]) begin
        r_d = trial[32:0];
        q_d = {q_q[30:0], 1'b1};
      end else begin
        r_d = {r_q[31:0], q_q[31]};
        q_d = {q_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; d_q <= d_d; neg_q <= neg_d;
  end

  assign done_o = !busy_q;
  assign qadj   = q_q + {31'd0, (r_q != '0)};
  assign quot_o = neg_q ? (~qadj + 32'd1) : q_q;
endmodule

FILE: rtl/voxel_hash_insert.sv
// Top level of the voxel hash insert block: sequencer, hash, chain walk, pool.
// Depends on vhi_pkg, vhi_if, vhi_ram, vhi_div and assert_macros.svh.
//
//  channel   dir  payload
//  in_ch     in   point_x, point_y, point_z
//  out_ch    out  status, bucket, cell_x..z, voxel_total, chained_total
//  cfg_ch    in   cell edge length
//
// An item passes through the idle state, three divisions, a hash multiply for
// each of the three cells, the bucket head read, a node read for each chain
// node visited, an insert when no match is found and the pool is not full,
// and a result. After reset a clearing pass runs over all 4096 entries of the
// bucket table; no item is accepted meanwhile. A stalled result holds the
// block in its output state.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module voxel_hash_insert import vhi_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  vhi_in_if.sink  in_ch,
  vhi_out_if.source out_ch,
  vhi_cfg_if.sink cfg_ch
);
  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_DSTRT = 11'b00000000100,
    S_DWAIT = 11'b00000001000,
    S_HASH  = 11'b00000010000,
    S_HREAD = 11'b00000100000,
    S_HWAIT = 11'b00001000000,
    S_NREAD = 11'b00010000000,
    S_NWAIT = 11'b00100000000,
    S_CMP   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic [31:0] vsize_q;
  logic [31:0] pt_q [3];
  logic [31:0] cell_q [3], cell_d [3];
  logic [1:0]  idx_q, idx_d;
  logic [31:0] hash_q, hash_d;
  logic [BktW-1:0] clr_q, clr_d;
  logic [NodeW-1:0] cur_q, cur_d, tail_q, tail_d;
  logic had_q, had_d;
  logic [CntW-1:0] vcnt_q, vcnt_d, ccnt_q, ccnt_d;
  logic [1:0] st_q, st_d;
  logic [NodeW:0] steps_q, steps_d;

  logic hd_we, nd_we, lk_we;
  logic [BktW-1:0] hd_addr_w;
  logic [NodeW:0] hd_wdata, hd_rdata, lk_wdata, lk_rdata;
  logic [NodeW-1:0] nd_addr_w, lk_addr_w;
  logic [95:0] nd_rdata;

  div_ctrl_t dctl;
  logic div_done;
  logic [31:0] div_q, mag, prime, prod;
  logic [BktW-1:0] bkt;
  logic match;

  assign bkt = hash_q[BktW-1:0];
  assign mag = pt_q[idx_q][31] ? (~pt_q[idx_q] + 32'd1) : pt_q[idx_q];

  always_comb begin
    case (idx_q)
      2'd0:    prime = PrimeX;
      2'd1:    prime = PrimeY;
      default: prime = PrimeZ;
    endcase
  end
  assign prod  = cell_q[idx_q] * prime;
  assign match = nd_rdata == {cell_q[0], cell_q[1], cell_q[2]};

  vhi_div u_div (
    .clk_i, .rst_ni, .ctrl_i(dctl), .mag_i(mag), .divisor_i(vsize_q),
    .done_o(div_done), .quot_o(div_q)
  );

  vhi_ram #(.Width(NodeW + 1), .Depth(Buckets)) u_head (
    .clk_i, .we_i(hd_we), .waddr_i(hd_addr_w), .wdata_i(hd_wdata),
    .raddr_i(bkt), .rdata_o(hd_rdata)
  );
  vhi_ram #(.Width(96), .Depth(PoolNodes)) u_coord (
    .clk_i, .we_i(nd_we), .waddr_i(nd_addr_w),
    .wdata_i({cell_q[0], cell_q[1], cell_q[2]}), .raddr_i(cur_q), .rdata_o(nd_rdata)
  );
  vhi_ram #(.Width(NodeW + 1), .Depth(PoolNodes)) u_link (
    .clk_i, .we_i(lk_we), .waddr_i(lk_addr_w), .wdata_i(lk_wdata),
    .raddr_i(cur_q), .rdata_o(lk_rdata)
  );

  always_comb begin
    state_d = state_q; idx_d = idx_q; hash_d = hash_q; clr_d = clr_q;
    cur_d = cur_q; tail_d = tail_q; had_d = had_q; vcnt_d = vcnt_q;
    ccnt_d = ccnt_q; st_d = st_q; steps_d = steps_q;
    for (int i = 0; i < 3; i++) cell_d[i] = cell_q[i];
    dctl = '0;
    hd_we = 1'b0; hd_addr_w = clr_q; hd_wdata = '0;
    nd_we = 1'b0; nd_addr_w = vcnt_q[NodeW-1:0];
    lk_we = 1'b0; lk_addr_w = vcnt_q[NodeW-1:0]; lk_wdata = '0;
    case (state_q)
      S_CLEAR: begin
        hd_we = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == BktW'(Buckets - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        idx_d = '0;
        if (in_ch.valid) state_d = S_DSTRT;
      end
      S_DSTRT: begin
        dctl.start = 1'b1;
        dctl.neg = pt_q[idx_q][31];
        state_d = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          cell_d[idx_q] = div_q;
          if (idx_q == 2'd2) begin
            idx_d = '0; hash_d = '0; state_d = S_HASH;
          end else begin
            idx_d = idx_q + 2'd1; state_d = S_DSTRT;
          end
        end
      end
      S_HASH: begin
        hash_d = hash_q ^ prod;
        if (idx_q == 2'd2) state_d = S_HREAD;
        else idx_d = idx_q + 2'd1;
      end
      S_HREAD: state_d = S_HWAIT;
      S_HWAIT: begin
        had_d = 1'b0; steps_d = '0;
        cur_d = hd_rdata[NodeW-1:0];
        state_d = hd_rdata[NodeW] ? S_NREAD : S_CMP;
      end
      S_NREAD: state_d = S_NWAIT;
      S_NWAIT: begin
        had_d = 1'b1;
        steps_d = steps_q + 1'b1;
        if (match) begin
          st_d = ST_PRESENT; state_d = S_OUT;
        end else begin
          tail_d = cur_q;
          cur_d = lk_rdata[NodeW-1:0];
          if (lk_rdata[NodeW] && (steps_q + 1'b1) < (NodeW + 1)'(PoolNodes))
            state_d = S_NREAD;
          else state_d = S_CMP;
        end
      end
      S_CMP: begin
        state_d = S_OUT;
        if (vcnt_q >= CntW'(PoolNodes)) begin
          st_d = ST_FULL;
        end else begin
          nd_we = 1'b1; lk_we = 1'b1;
          vcnt_d = vcnt_q + 1'b1;
          if (had_q) begin
            st_d = ST_CHAIN;
            ccnt_d = ccnt_q + 1'b1;
          end else begin
            st_d = ST_HEAD;
            hd_we = 1'b1; hd_addr_w = bkt; hd_wdata = {1'b1, vcnt_q[NodeW-1:0]};
          end
        end
      end
      S_OUT: begin
        if (had_q && st_q == ST_CHAIN && !lk_we) begin
          lk_we = 1'b1; lk_addr_w = tail_q;
          lk_wdata = {1'b1, NodeW'(vcnt_q - 1'b1)};
        end
        if (out_ch.ready) state_d = S_IDLE;
        had_d = 1'b0;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; clr_q <= '0; vcnt_q <= '0; ccnt_q <= '0;
      vsize_q <= 32'd65536; had_q <= 1'b0;
    end else begin
      state_q <= state_d; clr_q <= clr_d; vcnt_q <= vcnt_d; ccnt_q <= ccnt_d;
      had_q <= had_d;
      if (cfg_ch.valid) vsize_q <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; hash_q <= hash_d; cur_q <= cur_d; tail_q <= tail_d;
    st_q <= st_d; steps_q <= steps_d;
    for (int i = 0; i < 3; i++) cell_q[i] <= cell_d[i];
    if (state_q == S_IDLE && in_ch.valid) begin
      pt_q[0] <= in_ch.data.point_x;
      pt_q[1] <= in_ch.data.point_y;
      pt_q[2] <= in_ch.data.point_z;
    end
  end

  assign in_ch.ready  = state_q == S_IDLE;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = state_q == S_OUT;
  assign out_ch.data  = '{status: st_q, bucket: 12'(bkt), cell_x: cell_q[0],
                          cell_y: cell_q[1], cell_z: cell_q[2],
                          voxel_total: 13'(vcnt_q), chained_total: 13'(ccnt_q)};

  `ASSERT_NEVER(a_cnt_order, clk_i, rst_ni, ccnt_q > vcnt_q)
  `ASSERT_NEVER(a_cnt_max, clk_i, rst_ni, vcnt_q > CntW'(PoolNodes))
  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni,
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(vcnt_q))
  `ASSERT_NEVER(a_busy_in, clk_i, rst_ni, in_ch.ready && out_ch.valid)
endmodule
